// ===== rtl/core/dopr_pkg.sv =====
// shared types and codes for the drop-oldest packet descriptor ring
package dopr_pkg;

    localparam logic [1:0] OP_PUBLISH = 2'd0;
    localparam logic [1:0] OP_CONSUME = 2'd1;
    localparam logic [1:0] OP_FINISH  = 2'd2;

    localparam logic [3:0] ST_PUBLISHED      = 4'd0;
    localparam logic [3:0] ST_PUBLISHED_DROP = 4'd1;
    localparam logic [3:0] ST_CONSUMED       = 4'd2;
    localparam logic [3:0] ST_EMPTY_RUNNING  = 4'd3;
    localparam logic [3:0] ST_STOPPED        = 4'd4;
    localparam logic [3:0] ST_STOPPED_ERROR  = 4'd5;
    localparam logic [3:0] ST_BAD_REQUEST    = 4'd6;
    localparam logic [3:0] ST_CAPACITY_SMALL = 4'd7;
    localparam logic [3:0] ST_FINISH_NOTED   = 4'd8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_FRAMES = 2'd1;

    localparam logic [7:0]  SLOT_COUNT_RESET    = 8'd8;
    localparam logic [12:0] PERIOD_FRAMES_RESET = 13'd256;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [12:0] frames;
        logic [47:0] stamp_us;
        logic [15:0] reader_capacity;
        logic [7:0]  finish_code;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [6:0]  slot_index;
        logic [31:0] packet_sequence;
        logic [31:0] packet_base_frame;
        logic [47:0] packet_stamp_us;
        logic [12:0] packet_frames;
        logic [7:0]  queued_count;
        logic [7:0]  error_out;
        logic [31:0] dropped_packet_count;
        logic [31:0] dropped_frame_count;
        logic [7:0]  high_watermark;
    } t_out_item;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] base_frame;
        logic [47:0] stamp;
        logic [12:0] frames;
    } t_entry;

    typedef struct packed {
        logic load;
        logic fix;
        logic exec;
    } t_ctrl_cmd;

endpackage

// ===== rtl/core/dopr_ctrl.sv =====
// sequencer for item load, pointer check with descriptor read, and execute
module dopr_ctrl import dopr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_fix;
    logic   r_exec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fix   <= 1'b0;
            r_exec  <= 1'b0;
        end else begin
            r_fix  <= 1'b0;
            r_exec <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_READ;
                        r_fix   <= 1'b1;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                    r_exec  <= 1'b1;
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_cmd.load = start && (r_state == S_IDLE);
    assign o_cmd.fix  = r_fix;
    assign o_cmd.exec = r_exec;

endmodule

// ===== rtl/core/dopr_datapath.sv =====
// ring pointers, counters, descriptor memory and result register
module dopr_datapath import dopr_pkg::*; #(
    parameter int MAX_SLOTS  = 128,
    parameter int MAX_FRAMES = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ctrl_cmd              i_cmd,
    input  t_in_item               i_item,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_result_valid,
    output t_out_item              o_result
);

    localparam int PTR_W = $clog2(MAX_SLOTS);
    localparam int CW    = (PTR_W + 1 > 9) ? PTR_W + 1 : 9;

    logic [7:0]       r_slot_cfg;
    logic [12:0]      r_period;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [7:0]       r_fill;
    logic [31:0]      r_next_seq;
    logic [31:0]      r_next_frame;
    logic             r_finished;
    logic [7:0]       r_fin_err;
    logic [31:0]      r_drop_pk;
    logic [31:0]      r_drop_fr;
    logic [7:0]       r_peak;
    logic             r_res_valid;

    t_in_item  r_item;
    t_entry    r_rd_data;
    t_out_item r_res;
    t_entry    r_mem [MAX_SLOTS];

    logic [PTR_W-1:0] n_rd_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [7:0]       n_fill;
    logic [31:0]      n_next_seq;
    logic [31:0]      n_next_frame;
    logic             n_finished;
    logic [7:0]       n_fin_err;
    logic [31:0]      n_drop_pk;
    logic [31:0]      n_drop_fr;
    logic [7:0]       n_peak;
    t_out_item        n_res;

    logic [7:0]       slots_n;
    logic [15:0]      period_n;
    logic             ptr_bad;
    logic [PTR_W-1:0] rd_addr;
    logic             mem_we;
    t_entry           wr_entry;
    logic             full;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [7:0] n);
        logic [CW-1:0] q;
        q = CW'(p) + CW'(1);
        return (q >= CW'(n)) ? '0 : q[PTR_W-1:0];
    endfunction

    always_comb begin
        if (r_slot_cfg < 8'd2) begin
            slots_n = 8'd2;
        end else if (CW'(r_slot_cfg) > CW'(MAX_SLOTS)) begin
            slots_n = 8'(MAX_SLOTS);
        end else begin
            slots_n = r_slot_cfg;
        end
        if (r_period == 13'd0) begin
            period_n = 16'd1;
        end else if ({3'b000, r_period} > 16'(MAX_FRAMES)) begin
            period_n = 16'(MAX_FRAMES);
        end else begin
            period_n = {3'b000, r_period};
        end
    end

    assign ptr_bad = (CW'(r_rd_ptr) >= CW'(slots_n)) || (CW'(r_wr_ptr) >= CW'(slots_n))
                     || (r_fill > slots_n);
    assign rd_addr = ptr_bad ? '0 : r_rd_ptr;

    assign wr_entry.seq        = r_next_seq;
    assign wr_entry.base_frame = r_next_frame;
    assign wr_entry.stamp      = r_item.stamp_us;
    assign wr_entry.frames     = r_item.frames;
    assign full                = (r_fill >= slots_n);

    always_comb begin
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_fill       = r_fill;
        n_next_seq   = r_next_seq;
        n_next_frame = r_next_frame;
        n_finished   = r_finished;
        n_fin_err    = r_fin_err;
        n_drop_pk    = r_drop_pk;
        n_drop_fr    = r_drop_fr;
        n_peak       = r_peak;
        mem_we       = 1'b0;
        n_res        = '0;
        n_res.status = ST_BAD_REQUEST;
        case (r_item.opcode)
            OP_PUBLISH: begin
                if ((r_item.frames != 13'd0) && ({3'b000, r_item.frames} <= period_n)) begin
                    mem_we       = 1'b1;
                    n_res.status = ST_PUBLISHED;
                    if (full) begin
                        // oldest descriptor is overwritten
                        n_drop_pk    = r_drop_pk + 32'd1;
                        n_drop_fr    = r_drop_fr + 32'(r_rd_data.frames);
                        n_rd_ptr     = advance(r_rd_ptr, slots_n);
                        n_res.status = ST_PUBLISHED_DROP;
                    end else begin
                        n_fill = r_fill + 8'd1;
                    end
                    if (n_fill > r_peak) begin
                        n_peak = n_fill;
                    end
                    n_wr_ptr                = advance(r_wr_ptr, slots_n);
                    n_next_seq              = r_next_seq + 32'd1;
                    n_next_frame            = r_next_frame + 32'(r_item.frames);
                    n_res.slot_index        = 7'(r_wr_ptr);
                    n_res.packet_sequence   = wr_entry.seq;
                    n_res.packet_base_frame = wr_entry.base_frame;
                    n_res.packet_stamp_us   = wr_entry.stamp;
                    n_res.packet_frames     = wr_entry.frames;
                end
            end
            OP_CONSUME: begin
                if (r_item.reader_capacity < period_n) begin
                    n_res.status = ST_CAPACITY_SMALL;
                end else if (r_fill != 8'd0) begin
                    n_res.status            = ST_CONSUMED;
                    n_res.slot_index        = 7'(r_rd_ptr);
                    n_res.packet_sequence   = r_rd_data.seq;
                    n_res.packet_base_frame = r_rd_data.base_frame;
                    n_res.packet_stamp_us   = r_rd_data.stamp;
                    n_res.packet_frames     = r_rd_data.frames;
                    n_rd_ptr                = advance(r_rd_ptr, slots_n);
                    n_fill                  = r_fill - 8'd1;
                end else if (!r_finished) begin
                    n_res.status = ST_EMPTY_RUNNING;
                end else if (r_fin_err != 8'd0) begin
                    n_res.status = ST_STOPPED_ERROR;
                end else begin
                    n_res.status = ST_STOPPED;
                end
            end
            OP_FINISH: begin
                n_finished   = 1'b1;
                n_fin_err    = r_item.finish_code;
                n_res.status = ST_FINISH_NOTED;
            end
            default: begin
                n_res.status = ST_BAD_REQUEST;
            end
        endcase
        n_res.queued_count         = n_fill;
        n_res.error_out            = n_fin_err;
        n_res.dropped_packet_count = n_drop_pk;
        n_res.dropped_frame_count  = n_drop_fr;
        n_res.high_watermark       = n_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_cfg   <= SLOT_COUNT_RESET;
            r_period     <= PERIOD_FRAMES_RESET;
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_fill       <= '0;
            r_next_seq   <= '0;
            r_next_frame <= '0;
            r_finished   <= 1'b0;
            r_fin_err    <= '0;
            r_drop_pk    <= '0;
            r_drop_fr    <= '0;
            r_peak       <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.exec;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SLOT_COUNT: begin
                        r_slot_cfg <= i_cfg_data[7:0];
                        r_rd_ptr   <= '0;
                        r_wr_ptr   <= '0;
                        r_fill     <= '0;
                    end
                    CFG_PERIOD_FRAMES: begin
                        r_period <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.fix && ptr_bad) begin
                r_rd_ptr <= '0;
                r_wr_ptr <= '0;
                r_fill   <= '0;
            end
            if (i_cmd.exec) begin
                r_rd_ptr     <= n_rd_ptr;
                r_wr_ptr     <= n_wr_ptr;
                r_fill       <= n_fill;
                r_next_seq   <= n_next_seq;
                r_next_frame <= n_next_frame;
                r_finished   <= n_finished;
                r_fin_err    <= n_fin_err;
                r_drop_pk    <= n_drop_pk;
                r_drop_fr    <= n_drop_fr;
                r_peak       <= n_peak;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (i_cmd.exec && mem_we) begin
            r_mem[r_wr_ptr] <= wr_entry;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

endmodule

// ===== rtl/core/drop_oldest_packet_ring_core.sv =====
// top level of the drop-oldest packet descriptor ring
// An item is taken when start is high and busy is low; its result appears on
// o_result with o_result_valid high for exactly one cycle once the item has
// been executed, and the receiver cannot stall it. Each item goes through load,
// pointer check with descriptor memory read, and execute with memory write,
// the single-port descriptor memory being read ahead of the update; a new item
// may be started in the cycle the previous result is shown. Publishing never
// blocks: a full ring overwrites its oldest descriptor and counts the drop.
// Config writes are always ready and belong only between items; writing the
// slot count empties the ring. No clearing pass after reset.
module drop_oldest_packet_ring_core import dopr_pkg::*; #(
    parameter int MAX_SLOTS  = 128,
    parameter int MAX_FRAMES = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  t_in_item               i_item,
    output logic                   o_result_valid,
    output t_out_item              o_result,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_ctrl_cmd cmd;

    dopr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    dopr_datapath #(
        .MAX_SLOTS  (MAX_SLOTS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_item         (i_item),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    assign o_cfg_ready = 1'b1;

endmodule
